### hw/rtl/filtered_pid_position_loop_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the filtered PID position loop
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FILTERED_PID_POSITION_LOOP_UNIT_MACROS_SVH
`define FILTERED_PID_POSITION_LOOP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPID_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPID_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fpid_pkg.sv
// ----------------------------------------------------------------------------
// fpid_pkg
// Types, constants and helper functions shared by the filtered PID loop.
// ----------------------------------------------------------------------------
package fpid_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ALPHA    = 3'd0,
        REG_PROP_GAIN       = 3'd1,
        REG_INTEG_GAIN_DT   = 3'd2,
        REG_DERIV_GAIN_DT   = 3'd3,
        REG_CTRL_ENABLE     = 3'd4,
        REG_INV_REDUCTION   = 3'd5,
        REG_TICK_PERIOD     = 3'd6
    } cfg_reg_t;

    localparam logic [15:0]        ALPHA_RESET      = 16'd32047;
    localparam logic signed [31:0] KP_RESET         = 32'sd268435;
    localparam logic signed [31:0] KI_RESET         = 32'sd470;
    localparam logic signed [31:0] KD_RESET         = 32'sd383479;
    localparam logic [16:0]        INV_RED_RESET    = 17'd65536;
    localparam logic [15:0]        TICK_RESET       = 16'd350;
    localparam logic signed [31:0] HELD_RESET       = 32'sd2949120;
    localparam logic [15:0]        ALPHA_ONE        = 16'd32768;
    localparam logic signed [52:0] ROUND_HALF       = 53'sd16384;

    typedef struct packed {
        logic [15:0]        filter_alpha;
        logic signed [31:0] proportional_gain;
        logic signed [31:0] integral_gain_dt;
        logic signed [31:0] derivative_gain_dt;
        logic               controller_enable;
        logic [16:0]        inverse_reduction;
        logic [15:0]        tick_period_us;
    } fpid_cfg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SHAFT_INV,
        MUL_HELD_A,
        MUL_FT_B,
        MUL_PAD_A,
        MUL_FP_B,
        MUL_KP_ERR,
        MUL_KD_DIFF,
        MUL_KI_HI,
        MUL_KI_LO
    } mul_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_PADDLE,
        OP_ACC_RND,
        OP_FT,
        OP_FP,
        OP_ERR,
        OP_INTEG,
        OP_ACC_T0,
        OP_ACC_T1,
        OP_TMP_LOAD,
        OP_TMP_ADD,
        OP_ACC_KI,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        dp_op_t   op;
    } fpid_cmd_t;

    typedef struct packed {
        logic loop_on;
    } fpid_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PADDLE,
        ST_MUL_TGT_NEW,
        ST_MUL_TGT_OLD,
        ST_MUL_PAD_NEW,
        ST_MUL_PAD_OLD,
        ST_FP,
        ST_ERR,
        ST_MUL_KP,
        ST_MUL_KD,
        ST_MUL_KI_HI,
        ST_MUL_KI_LO,
        ST_KI_ADD,
        ST_KI_ACC,
        ST_DONE
    } fpid_state_t;

    function automatic logic signed [31:0] sat_to32(input logic signed [52:0] v);
        if (v > 53'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -53'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

### hw/rtl/fpid_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpid_cfg_regs
// Configuration register file written over the valid/ready write channel.
// ----------------------------------------------------------------------------
module fpid_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    output fpid_pkg::fpid_cfg_t          cfg
);
    import fpid_pkg::*;

    fpid_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha       <= ALPHA_RESET;
            cfg_reg.proportional_gain  <= KP_RESET;
            cfg_reg.integral_gain_dt   <= KI_RESET;
            cfg_reg.derivative_gain_dt <= KD_RESET;
            cfg_reg.controller_enable  <= 1'b0;
            cfg_reg.inverse_reduction  <= INV_RED_RESET;
            cfg_reg.tick_period_us     <= TICK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FILTER_ALPHA:  cfg_reg.filter_alpha       <= cfg_data[15:0];
                REG_PROP_GAIN:     cfg_reg.proportional_gain  <= cfg_data;
                REG_INTEG_GAIN_DT: cfg_reg.integral_gain_dt   <= cfg_data;
                REG_DERIV_GAIN_DT: cfg_reg.derivative_gain_dt <= cfg_data;
                REG_CTRL_ENABLE:   cfg_reg.controller_enable  <= cfg_data[0];
                REG_INV_REDUCTION: cfg_reg.inverse_reduction  <= cfg_data[16:0];
                REG_TICK_PERIOD:   cfg_reg.tick_period_us     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/fpid_datapath.sv
// ----------------------------------------------------------------------------
// fpid_datapath
// Shared multiplier, accumulator, loop state and output word registers.
// ----------------------------------------------------------------------------
`include "filtered_pid_position_loop_unit_macros.svh"

module fpid_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpid_pkg::fpid_cfg_t    cfg,
    input  fpid_pkg::fpid_cmd_t    cmd,
    output fpid_pkg::fpid_status_t status,
    input  logic signed [31:0]     shaft_angle,
    input  logic                   setpoint_valid,
    input  logic signed [31:0]     new_setpoint,
    output logic signed [31:0]     drive_torque,
    output logic signed [31:0]     filtered_target,
    output logic signed [31:0]     filtered_paddle,
    output logic [31:0]            time_stamp
);
    import fpid_pkg::*;

    // Loop state.
    logic signed [31:0] held_reg;
    logic signed [31:0] ft_reg;
    logic signed [31:0] fp_reg;
    logic signed [31:0] prev_err_reg;
    logic signed [47:0] integ_reg;
    logic [31:0]        elapsed_reg;

    // Working registers.
    logic signed [31:0] shaft_reg;
    logic signed [31:0] paddle_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] diff_reg;
    logic signed [64:0] prod_reg;
    logic signed [64:0] tmp_reg;
    logic signed [52:0] acc_reg;

    // Output word.
    logic signed [31:0] torque_out_reg;
    logic signed [31:0] target_out_reg;
    logic signed [31:0] paddle_out_reg;
    logic [31:0]        stamp_out_reg;

    logic [15:0]        alpha_eff;
    logic [15:0]        alpha_comp;
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] prod_next;
    logic signed [31:0] paddle_next;
    logic signed [52:0] filt_sum;
    logic signed [31:0] filt_next;
    logic signed [31:0] err_next;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_next;
    logic signed [32:0] diff_next;
    logic signed [52:0] term_next;
    logic [31:0]        elapsed_next;

    assign status.loop_on = cfg.controller_enable;

    // Weights above one act as one.
    assign alpha_eff  = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
    assign alpha_comp = ALPHA_ONE - alpha_eff;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SHAFT_INV:
            begin
                mul_a = shaft_reg;
                mul_b = $signed({16'd0, cfg.inverse_reduction});
            end
            MUL_HELD_A:
            begin
                mul_a = held_reg;
                mul_b = $signed({17'd0, alpha_eff});
            end
            MUL_FT_B:
            begin
                mul_a = ft_reg;
                mul_b = $signed({17'd0, alpha_comp});
            end
            MUL_PAD_A:
            begin
                mul_a = paddle_reg;
                mul_b = $signed({17'd0, alpha_eff});
            end
            MUL_FP_B:
            begin
                mul_a = fp_reg;
                mul_b = $signed({17'd0, alpha_comp});
            end
            MUL_KP_ERR:
            begin
                mul_a = cfg.proportional_gain;
                mul_b = $signed({err_reg[31], err_reg});
            end
            MUL_KD_DIFF:
            begin
                mul_a = cfg.derivative_gain_dt;
                mul_b = diff_reg;
            end
            MUL_KI_HI:
            begin
                mul_a = cfg.integral_gain_dt;
                mul_b = $signed({integ_reg[47], integ_reg[47:16]});
            end
            MUL_KI_LO:
            begin
                mul_a = cfg.integral_gain_dt;
                mul_b = $signed({17'd0, integ_reg[15:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 65'(mul_a) * 65'(mul_b);

    assign paddle_next = sat_to32(53'(prod_reg >>> 16));
    assign filt_sum    = acc_reg + 53'(prod_reg);
    assign filt_next   = sat_to32(filt_sum >>> 15);
    assign err_next    = sat_to32(53'(ft_reg) - 53'(fp_reg));
    assign diff_next   = 33'(err_reg) - 33'(prev_err_reg);
    assign term_next   = 53'(prod_reg >>> 28);
    assign elapsed_next = elapsed_reg + 32'(cfg.tick_period_us);

    // The integral clamps to the signed 48-bit range when the add overflows.
    assign integ_sum = 49'(integ_reg) + 49'(err_reg);
    always_comb
    begin
        if (integ_sum[48] != integ_sum[47])
            integ_next = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            integ_next = integ_sum[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= HELD_RESET;
            ft_reg       <= '0;
            fp_reg       <= '0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            elapsed_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD_IN:
                begin
                    if (setpoint_valid)
                        held_reg <= new_setpoint;
                end
                OP_FT:     ft_reg <= filt_next;
                OP_FP:     fp_reg <= filt_next;
                OP_INTEG:
                begin
                    integ_reg    <= integ_next;
                    prev_err_reg <= err_reg;
                end
                OP_FINISH: elapsed_reg <= elapsed_next;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.op)
            OP_LOAD_IN:  shaft_reg  <= shaft_angle;
            OP_PADDLE:   paddle_reg <= paddle_next;
            OP_ACC_RND:  acc_reg    <= 53'(prod_reg) + ROUND_HALF;
            OP_ERR:      err_reg    <= err_next;
            OP_INTEG:    diff_reg   <= diff_next;
            OP_ACC_T0:   acc_reg    <= term_next;
            OP_ACC_T1:   acc_reg    <= acc_reg + term_next;
            OP_TMP_LOAD: tmp_reg    <= prod_reg;
            OP_TMP_ADD:  tmp_reg    <= tmp_reg + (prod_reg >>> 16);
            OP_ACC_KI:   acc_reg    <= acc_reg + 53'(tmp_reg >>> 12);
            OP_FINISH:
            begin
                torque_out_reg <= cfg.controller_enable ? sat_to32(acc_reg) : '0;
                target_out_reg <= ft_reg;
                paddle_out_reg <= fp_reg;
                stamp_out_reg  <= elapsed_next;
            end
            default:
            begin
            end
        endcase
    end

    assign drive_torque    = torque_out_reg;
    assign filtered_target = target_out_reg;
    assign filtered_paddle = paddle_out_reg;
    assign time_stamp      = stamp_out_reg;

    `FPID_ASSERT_NXT(a_stamp_matches_elapsed, cmd.op == OP_FINISH,
        time_stamp == elapsed_reg, "time stamp word differs from the elapsed time")
    `FPID_ASSERT_NXT(a_disabled_zero_torque,
        cmd.op == OP_FINISH && !cfg.controller_enable,
        drive_torque == 32'sd0, "disabled loop produced a nonzero torque")
    `FPID_ASSERT_IMP(a_alpha_capped, cmd.mul_sel == MUL_HELD_A,
        alpha_eff <= ALPHA_ONE, "filter weight exceeds one")

endmodule

### hw/rtl/fpid_ctrl.sv
// ----------------------------------------------------------------------------
// fpid_ctrl
// Sequencer for one control tick and owner of the output word valid flag.
// ----------------------------------------------------------------------------
`include "filtered_pid_position_loop_unit_macros.svh"

module fpid_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  fpid_pkg::fpid_status_t status,
    output fpid_pkg::fpid_cmd_t    cmd
);
    import fpid_pkg::*;

    fpid_state_t state_reg;
    fpid_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        finish;

    // The word can be loaded once the output register is empty or being drained.
    assign finish = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (in_valid) state_next = ST_MUL_PADDLE;
            ST_MUL_PADDLE:  state_next = ST_MUL_TGT_NEW;
            ST_MUL_TGT_NEW: state_next = ST_MUL_TGT_OLD;
            ST_MUL_TGT_OLD: state_next = ST_MUL_PAD_NEW;
            ST_MUL_PAD_NEW: state_next = ST_MUL_PAD_OLD;
            ST_MUL_PAD_OLD: state_next = ST_FP;
            ST_FP:          state_next = ST_ERR;
            ST_ERR:         state_next = status.loop_on ? ST_MUL_KP : ST_DONE;
            ST_MUL_KP:      state_next = ST_MUL_KD;
            ST_MUL_KD:      state_next = ST_MUL_KI_HI;
            ST_MUL_KI_HI:   state_next = ST_MUL_KI_LO;
            ST_MUL_KI_LO:   state_next = ST_KI_ADD;
            ST_KI_ADD:      state_next = ST_KI_ACC;
            ST_KI_ACC:      state_next = ST_DONE;
            ST_DONE:        if (finish) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.mul_sel = MUL_NONE;
        cmd.op      = OP_NONE;
        case (state_reg)
            ST_IDLE:        cmd.op = in_valid ? OP_LOAD_IN : OP_NONE;
            ST_MUL_PADDLE:  cmd.mul_sel = MUL_SHAFT_INV;
            ST_MUL_TGT_NEW:
            begin
                cmd.mul_sel = MUL_HELD_A;
                cmd.op      = OP_PADDLE;
            end
            ST_MUL_TGT_OLD:
            begin
                cmd.mul_sel = MUL_FT_B;
                cmd.op      = OP_ACC_RND;
            end
            ST_MUL_PAD_NEW:
            begin
                cmd.mul_sel = MUL_PAD_A;
                cmd.op      = OP_FT;
            end
            ST_MUL_PAD_OLD:
            begin
                cmd.mul_sel = MUL_FP_B;
                cmd.op      = OP_ACC_RND;
            end
            ST_FP:          cmd.op = OP_FP;
            ST_ERR:         cmd.op = OP_ERR;
            ST_MUL_KP:
            begin
                cmd.mul_sel = MUL_KP_ERR;
                cmd.op      = OP_INTEG;
            end
            ST_MUL_KD:
            begin
                cmd.mul_sel = MUL_KD_DIFF;
                cmd.op      = OP_ACC_T0;
            end
            ST_MUL_KI_HI:
            begin
                cmd.mul_sel = MUL_KI_HI;
                cmd.op      = OP_ACC_T1;
            end
            ST_MUL_KI_LO:
            begin
                cmd.mul_sel = MUL_KI_LO;
                cmd.op      = OP_TMP_LOAD;
            end
            ST_KI_ADD:      cmd.op = OP_TMP_ADD;
            ST_KI_ACC:      cmd.op = OP_ACC_KI;
            ST_DONE:        cmd.op = finish ? OP_FINISH : OP_NONE;
            default:
            begin
                cmd.mul_sel = MUL_NONE;
                cmd.op      = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        if (finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FPID_ASSERT_NXT(a_accept_starts_tick, in_valid && !in_stall,
        state_reg == ST_MUL_PADDLE, "accepted word did not start a tick")
    `FPID_ASSERT_NXT(a_disabled_skips_pid, state_reg == ST_ERR && !status.loop_on,
        state_reg == ST_DONE, "disabled loop entered the PID steps")
    `FPID_ASSERT_NXT(a_finish_sets_valid, finish,
        out_valid && state_reg == ST_IDLE, "finished tick did not present its word")

endmodule

### hw/rtl/filtered_pid_position_loop_unit.sv
// ----------------------------------------------------------------------------
// filtered_pid_position_loop_unit
// Low-pass filtered PID position loop, one result word per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one word per control tick:
//   the shaft angle and an optional new setpoint, which is held until replaced.
//   The output channel (out_valid / out_stall) returns one word per tick with
//   the torque, both filtered angles and the time stamp.
//   Configuration is written through cfg_valid / cfg_ready with a register
//   index and 32-bit data; the user must write it only while no tick is in
//   flight, which the block itself does not enforce. One 32 x 33 multiplier
//   is shared by all products, so a tick is sequenced and no new word is
//   accepted before the last tick is done; disabled, PID steps are skipped.
//   A finished word sits in an output register; if the receiver stalls, the
//   next tick is accepted and computed, then waits until that register frees.
//   Reset restores the register defaults, sets the held setpoint to 45 degrees
//   and clears the filters, integral, previous error and elapsed time.
// ----------------------------------------------------------------------------
module filtered_pid_position_loop_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             shaft_angle,
    input  logic                           setpoint_valid,
    input  logic signed [31:0]             new_setpoint,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             drive_torque,
    output logic signed [31:0]             filtered_target,
    output logic signed [31:0]             filtered_paddle,
    output logic [31:0]                    time_stamp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import fpid_pkg::*;

    fpid_cfg_t    cfg;
    fpid_cmd_t    cmd;
    fpid_status_t status;

    fpid_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fpid_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .shaft_angle     (shaft_angle),
        .setpoint_valid  (setpoint_valid),
        .new_setpoint    (new_setpoint),
        .drive_torque    (drive_torque),
        .filtered_target (filtered_target),
        .filtered_paddle (filtered_paddle),
        .time_stamp      (time_stamp)
    );

endmodule
